### rtl/core/pava_pkg.sv
// Package: shared types and constants of the PAVA isotonic regression block.
`timescale 1ns / 1ps
`default_nettype none
package pava_pkg;
    localparam int MaxSamples = 64;
    localparam int IdxW  = $clog2(MaxSamples);
    localparam int CntW  = IdxW + 1;
    localparam int SumW  = 38;
    localparam int DatW  = 32;
    localparam int DivW  = SumW;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;       // write new block at top
        logic rd_pair;    // register top and below-top entries
        logic cmp;        // register the compare operands
        logic merge;      // pool top into below-top
        logic end_push;   // finish the push
        logic emit_init;  // start the emission walk
        logic ld_blk;     // load the current block
        logic div_start;  // start the divider
        logic emit_adv;   // one result taken
        logic run_clr;    // clear run counters
    } pava_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic violate;    // below-top mean is greater than top mean
        logic has_below;  // stack holds two or more blocks
        logic run_end;    // run ends with this sample
        logic div_done;   // quotient ready
        logic blk_last;   // last sample of the current block
        logic run_last;   // last sample of the run
    } pava_sts_t;
endpackage
`default_nettype wire

### rtl/core/isotonic_regression_pava_top.sv
// Top level: isotonic regression by pool-adjacent-violators over a sample stream.
//
//  channel | dir | tdata bits                  | tlast
//  s_      | in  | [31:0] sample               | final_sample
//  m_      | out | [31:0] fitted               | final_output
//
//  A sample is pushed; when a block lies below it, the top two blocks are then
//  read, loaded, cross-multiplied and compared, and each merge repeats the read
//  and the compare.
//  Emission per block reads, loads, starts the divider and runs a serial divide,
//  one quotient bit a cycle, then one fitted value a cycle while m_tready is high.
//  Reset (aresetn low, synchronous) empties the stack; contents are not cleared.
//  Input is held off while a merge or an emission runs; m_tvalid holds under stall.
`timescale 1ns / 1ps
`default_nettype none
module isotonic_regression_pava_top
    import pava_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample
    input  wire logic        s_tlast,   // final_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] fitted
    output logic             m_tlast    // final_output
);
    pava_cmd_t cmd;
    pava_sts_t sts;

    pava_ctl u_ctl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .out_last  (m_tlast)
    );

    pava_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sample       (s_tdata),
        .final_sample (s_tlast),
        .sts          (sts),
        .fitted       (m_tdata)
    );
endmodule
`default_nettype wire

### rtl/core/pava_div.sv
// Divider: restoring signed division, one quotient bit a cycle, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module pava_div
    import pava_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic signed [SumW-1:0] dividend,
    input  wire logic        [CntW-1:0] divisor,
    output logic                        done,
    output logic signed [DatW-1:0]      quotient
);
    localparam int StepW = $clog2(DivW + 1);

    logic [DivW-1:0]  quo_reg, quo_next;
    logic [CntW:0]    rem_reg, rem_next;
    logic [CntW-1:0]  dsr_reg, dsr_next;
    logic             neg_reg, neg_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic [CntW:0]    trial;
    logic [DivW-1:0]  qfix;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[CntW-1:0], quo_reg[DivW-1]};
        if (start) begin
            quo_next  = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[SumW-1];
            step_next = StepW'(DivW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DivW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DivW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign qfix     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient = qfix[DatW-1:0];
    assign done     = !busy_reg && !start;
endmodule
`default_nettype wire

### rtl/core/pava_dp.sv
// Datapath: block stack memory, cross-product compare, merge and emission walk.
`timescale 1ns / 1ps
`default_nettype none
module pava_dp
    import pava_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pava_cmd_t             cmd,
    input  wire logic [DatW-1:0]       sample,
    input  wire logic                  final_sample,
    output pava_sts_t                  sts,
    output logic [DatW-1:0]            fitted
);
    localparam int ProdW = SumW + CntW;

    logic [SumW+CntW+IdxW-1:0] stk_mem [MaxSamples];

    logic [CntW-1:0] depth_reg, depth_next;   // blocks on stack
    logic [CntW-1:0] seen_reg, seen_next;     // samples in run
    logic            end_reg, end_next;       // run ends after this push

    logic signed [SumW-1:0] sum_t_reg, sum_b_reg;
    logic [CntW-1:0]        cnt_t_reg, cnt_b_reg;
    logic [IdxW-1:0]        st_b_reg;
    logic signed [ProdW-1:0] pl_reg, pr_reg;

    logic [IdxW-1:0]        blk_reg;          // emission block
    logic [CntW-1:0]        out_reg;          // emission sample
    logic [CntW-1:0]        blk_end_reg;      // end index of block, exclusive
    logic signed [SumW-1:0] e_sum_reg;
    logic [CntW-1:0]        e_cnt_reg;
    logic [SumW+CntW+IdxW-1:0] rd_a_reg, rd_b_reg;
    logic [CntW-1:0]        top_i, below_i;
    logic                   div_done;

    assign top_i   = depth_reg - 1'b1;
    assign below_i = depth_reg - 2'd2;

    always_comb begin
        depth_next = depth_reg;
        seen_next  = seen_reg;
        end_next   = end_reg;
        if (cmd.push) begin
            depth_next = depth_reg + 1'b1;
            seen_next  = seen_reg + 1'b1;
            end_next   = final_sample || (seen_reg == CntW'(MaxSamples - 1));
        end else if (cmd.merge) begin
            depth_next = depth_reg - 1'b1;
        end
        if (cmd.run_clr) begin
            depth_next = '0;
            seen_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            seen_reg  <= '0;
            end_reg   <= 1'b0;
        end else begin
            depth_reg <= depth_next;
            seen_reg  <= seen_next;
            end_reg   <= end_next;
        end
    end

    // Stack memory: one write port, two read ports.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stk_mem[depth_reg[IdxW-1:0]] <= {{(SumW-DatW){sample[DatW-1]}}, sample,
                                             CntW'(1), seen_reg[IdxW-1:0]};
        end else if (cmd.merge) begin
            stk_mem[below_i[IdxW-1:0]] <= {sum_b_reg + sum_t_reg,
                                           cnt_b_reg + cnt_t_reg, st_b_reg};
        end
        if (cmd.rd_pair) begin
            rd_a_reg <= stk_mem[below_i[IdxW-1:0]];
        end else begin
            rd_a_reg <= stk_mem[blk_reg];
        end
        rd_b_reg <= stk_mem[top_i[IdxW-1:0]];
    end

    // Compare stage: top is always the block just pushed or just merged.
    always_ff @(posedge aclk) begin
        if (cmd.cmp) begin
            {sum_b_reg, cnt_b_reg, st_b_reg} <= rd_a_reg;
            {sum_t_reg, cnt_t_reg}           <= rd_b_reg[SumW+CntW+IdxW-1:IdxW];
        end
        pl_reg <= ProdW'(sum_b_reg) * $signed({1'b0, cnt_t_reg});
        pr_reg <= ProdW'(sum_t_reg) * $signed({1'b0, cnt_b_reg});
    end

    // Emission walk.
    always_ff @(posedge aclk) begin
        if (cmd.emit_init) begin
            blk_reg <= '0;
            out_reg <= '0;
        end else if (cmd.emit_adv) begin
            out_reg <= out_reg + 1'b1;
            if (out_reg + 1'b1 == blk_end_reg) begin
                blk_reg <= blk_reg + 1'b1;
            end
        end
        if (cmd.ld_blk) begin
            {e_sum_reg, e_cnt_reg} <= rd_a_reg[SumW+CntW+IdxW-1:IdxW];
            blk_end_reg            <= CntW'(rd_a_reg[IdxW-1:0]) + rd_a_reg[IdxW+CntW-1:IdxW];
        end
    end

    pava_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (e_sum_reg),
        .divisor  (e_cnt_reg),
        .done     (div_done),
        .quotient (fitted)
    );

    assign sts.violate   = pl_reg > pr_reg;
    assign sts.has_below = depth_reg >= CntW'(2);
    assign sts.run_end   = end_reg;
    assign sts.div_done  = div_done;
    assign sts.blk_last  = (out_reg + 1'b1 == blk_end_reg);
    assign sts.run_last  = (out_reg + 1'b1 == seen_reg);

    property p_depth_le_seen;
        @(posedge aclk) disable iff (!aresetn) depth_reg <= seen_reg;
    endproperty
    a_depth_le_seen: assert property (p_depth_le_seen)
        else $error("more blocks than samples");
    a_seen_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= CntW'(MaxSamples)) else $error("run over capacity");
    a_merge_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.merge |-> depth_reg >= CntW'(2)) else $error("merge without two blocks");
endmodule
`default_nettype wire

### rtl/core/pava_ctl.sv
// Controller: sequences push, merge compare and emission.
`timescale 1ns / 1ps
`default_nettype none
module pava_ctl
    import pava_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire pava_sts_t sts,
    output pava_cmd_t      cmd,
    output logic           out_last
);
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_LD   = 10'b0000000100,
        S_MUL  = 10'b0000001000,
        S_CMP  = 10'b0000010000,
        S_ERD  = 10'b0000100000,
        S_ELD  = 10'b0001000000,
        S_DST  = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.push   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (sts.has_below) begin
                    cmd.rd_pair = 1'b1;
                    state_next  = S_LD;
                end else if (sts.run_end) begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_ERD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_LD: begin
                cmd.cmp    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: state_next = S_CMP;
            S_CMP: begin
                if (sts.violate) begin
                    cmd.merge  = 1'b1;
                    state_next = S_RD;
                end else if (sts.run_end) begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_ERD;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_ERD: state_next = S_ELD;
            S_ELD: begin
                cmd.ld_blk = 1'b1;
                state_next = S_DST;
            end
            // Start the divider once the block operands are registered.
            S_DST: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.emit_adv = 1'b1;
                    if (sts.run_last) begin
                        cmd.run_clr = 1'b1;
                        state_next  = S_IDLE;
                    end else if (sts.blk_last) begin
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign out_last = sts.run_last;

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid)) else $error("both sides open");
    a_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> state_reg == S_RD) else $error("push not followed by read");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire
